>>> rtl/rrf_pkg.sv
// Shared types and constants for the ranked ring FIFO.
// Used by rrf_cells and ranked_ring_fifo_top; no dependencies.
package rrf_pkg;

    localparam int unsigned DEPTH_DEF = 1024;
    localparam int unsigned CNT_W     = 32;   // head / tail counter width
    localparam int unsigned TAG_W     = CNT_W + 1;  // rank / gap: empty flag + counter
    localparam int unsigned WORD_W    = 64;
    localparam int unsigned STAT_W    = 2;

    localparam logic [TAG_W-1:0] TAG_NONE = '1;   // empty rank / no gap

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_E_RD,
        S_E_CHK,
        S_E_GAP,
        S_D_RD,
        S_D_CHK,
        S_OUT
    } t_state;

    typedef struct packed {
        logic rank_we;
        logic gap_we;
        logic word_we;
    } t_cell_we;

endpackage

>>> rtl/ranked_ring_fifo_top.sv
// Top level of the ranked ring FIFO: handshake, sequencer, head/tail counters.
// Instantiates rrf_cells; uses rrf_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one operation per beat:
//   i_operation 0 enqueues i_data_in, 1 dequeues one word. Output channel
//   (o_out_valid / i_out_stall) returns one beat per operation: o_data_out
//   (zero unless a word was dequeued) and o_status (done, full, empty).
//   Sequence: an operation leaves the idle state for a memory read state and then
//   a check state, which registers the result unless gap marks follow; the block
//   takes no new beat until it is back in idle. Every extra enqueue probe over an
//   occupied cell or dequeue skip over a gap adds one more read and check; every
//   gap mark an enqueue leaves behind adds one gap-write state. An enqueue on a
//   full ring probes all DEPTH cells. The single read port forces a read per probe.
//   Reset: head and tail go to zero, then a clearing pass over all DEPTH cells
//   marks every cell empty with no gap; o_in_stall stays high meanwhile.
//   Output stall: a finished result waits in a holding register while the output
//   register is occupied; the block takes no new beat until it has passed its
//   result on to the output register.
module ranked_ring_fifo_top #(
    parameter int unsigned DEPTH = rrf_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_operation,
    input  logic [rrf_pkg::WORD_W-1:0]  i_data_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [rrf_pkg::WORD_W-1:0]  o_data_out,
    output logic [rrf_pkg::STAT_W-1:0]  o_status
);
    import rrf_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_head, n_head;
    logic [CNT_W-1:0]   r_tail, n_tail;
    logic [CNT_W-1:0]   r_pos, n_pos;     // enqueue probe position
    logic [AW-1:0]      r_cnt, n_cnt;     // probes / skips made so far
    logic [AW-1:0]      r_clr, n_clr;
    logic [WORD_W-1:0]  r_data, n_data;
    logic [WORD_W-1:0]  r_res_data, n_res_data;
    logic [STAT_W-1:0]  r_res_status, n_res_status;
    logic               r_out_valid, n_out_valid;
    logic [WORD_W-1:0]  r_data_out, n_data_out;
    logic [STAT_W-1:0]  r_status, n_status;

    t_cell_we           cell_we;
    logic [AW-1:0]      widx, ridx;
    logic [TAG_W-1:0]   rank_wd, gap_wd;
    logic [TAG_W-1:0]   rank_q, gap_q;
    logic [WORD_W-1:0]  word_q;

    logic               fin;
    logic [WORD_W-1:0]  fin_data;
    logic [STAT_W-1:0]  fin_status;
    logic               out_free;

    rrf_cells #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_cells (
        .i_clk     (i_clk),
        .i_we      (cell_we),
        .i_widx    (widx),
        .i_rank_wd (rank_wd),
        .i_gap_wd  (gap_wd),
        .i_word_wd (r_data),
        .i_ridx    (ridx),
        .o_rank_q  (rank_q),
        .o_gap_q   (gap_q),
        .o_word_q  (word_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_head      <= '0;
            r_tail      <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_cnt        <= n_cnt;
        r_data       <= n_data;
        r_res_data   <= n_res_data;
        r_res_status <= n_res_status;
        r_data_out   <= n_data_out;
        r_status     <= n_status;
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_pos        = r_pos;
        n_cnt        = r_cnt;
        n_clr        = r_clr;
        n_data       = r_data;
        n_res_data   = r_res_data;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && i_out_stall;
        n_data_out   = r_data_out;
        n_status     = r_status;
        cell_we      = '0;
        widx         = r_pos[AW-1:0];
        ridx         = r_pos[AW-1:0];
        rank_wd      = {1'b0, r_pos};
        gap_wd       = {1'b0, r_tail};
        fin          = 1'b0;
        fin_data     = '0;
        fin_status   = ST_DONE;

        case (r_state)
            S_CLR: begin
                cell_we.rank_we = 1'b1;
                cell_we.gap_we  = 1'b1;
                widx            = r_clr;
                rank_wd         = TAG_NONE;
                gap_wd          = TAG_NONE;
                n_clr           = r_clr + 1'b1;
                if (r_clr == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_data = i_data_in;
                    n_pos  = r_tail;
                    n_cnt  = '0;
                    if (i_operation == OP_ENQ) begin
                        n_state = S_E_RD;
                    end else begin
                        n_state = S_D_RD;
                    end
                end
            end
            S_E_RD: begin
                n_state = S_E_CHK;
            end
            S_E_CHK: begin
                if (rank_q[TAG_W-1]) begin
                    // free cell: take the word, then mark gaps on the skipped cells
                    cell_we.rank_we = 1'b1;
                    cell_we.word_we = 1'b1;
                    if (r_pos == r_tail) begin
                        n_tail = r_pos + 1'b1;
                        fin    = 1'b1;
                    end else begin
                        n_state = S_E_GAP;
                    end
                end else if (r_cnt == LAST_IDX) begin
                    fin        = 1'b1;
                    fin_status = ST_FULL;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_pos   = r_pos + 1'b1;
                    n_state = S_E_RD;
                end
            end
            S_E_GAP: begin
                cell_we.gap_we = 1'b1;
                widx           = r_tail[AW-1:0];
                if (r_tail + 1'b1 == r_pos) begin
                    n_tail = r_pos + 1'b1;
                    fin    = 1'b1;
                end else begin
                    n_tail = r_tail + 1'b1;
                end
            end
            S_D_RD: begin
                ridx    = r_head[AW-1:0];
                n_state = S_D_CHK;
            end
            S_D_CHK: begin
                widx = r_head[AW-1:0];
                if (rank_q == {1'b0, r_head}) begin
                    cell_we.rank_we = 1'b1;
                    rank_wd         = TAG_NONE;
                    n_head          = r_head + 1'b1;
                    fin             = 1'b1;
                    fin_data        = word_q;
                end else if (!gap_q[TAG_W-1] && gap_q[CNT_W-1:0] >= r_head) begin
                    n_head = r_head + 1'b1;
                    if (r_cnt == LAST_IDX) begin
                        fin        = 1'b1;
                        fin_status = ST_EMPTY;
                    end else begin
                        n_cnt   = r_cnt + 1'b1;
                        n_state = S_D_RD;
                    end
                end else begin
                    fin        = 1'b1;
                    fin_status = ST_EMPTY;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_data_out  = r_res_data;
                    n_status    = r_res_status;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            if (out_free) begin
                n_out_valid = 1'b1;
                n_data_out  = fin_data;
                n_status    = fin_status;
                n_state     = S_IDLE;
            end else begin
                n_res_data   = fin_data;
                n_res_status = fin_status;
                n_state      = S_OUT;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_data_out;
    assign o_status    = r_status;

endmodule

>>> rtl/rrf_cells.sv
// Cell store of the ranked ring FIFO: rank, gap and word memories.
// One shared write address, one shared read address, registered read data. Uses rrf_pkg.
module rrf_cells #(
    parameter int unsigned DEPTH = rrf_pkg::DEPTH_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  rrf_pkg::t_cell_we          i_we,
    input  logic [AW-1:0]              i_widx,
    input  logic [rrf_pkg::TAG_W-1:0]  i_rank_wd,
    input  logic [rrf_pkg::TAG_W-1:0]  i_gap_wd,
    input  logic [rrf_pkg::WORD_W-1:0] i_word_wd,
    input  logic [AW-1:0]              i_ridx,
    output logic [rrf_pkg::TAG_W-1:0]  o_rank_q,
    output logic [rrf_pkg::TAG_W-1:0]  o_gap_q,
    output logic [rrf_pkg::WORD_W-1:0] o_word_q
);
    import rrf_pkg::*;

    logic [TAG_W-1:0]  rank_mem [DEPTH];
    logic [TAG_W-1:0]  gap_mem  [DEPTH];
    logic [WORD_W-1:0] word_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we.rank_we) begin
            rank_mem[i_widx] <= i_rank_wd;
        end
        o_rank_q <= rank_mem[i_ridx];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.gap_we) begin
            gap_mem[i_widx] <= i_gap_wd;
        end
        o_gap_q <= gap_mem[i_ridx];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.word_we) begin
            word_mem[i_widx] <= i_word_wd;
        end
        o_word_q <= word_mem[i_ridx];
    end

endmodule
